// ===== src/lphm_pkg.sv =====
// Package for the linear probe hash map: table geometry, command and result
// beat types, status and opcode codes, and hash constants. No dependencies.
package lphm_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [SLOT_BITS:0] HALF_LOAD = (SLOT_BITS + 1)'(TABLE_SLOTS / 2);

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    localparam logic       OP_LOOKUP = 1'b0;
    localparam logic       OP_PUT    = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] bound_value;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] found_value;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [SLOT_BITS-1:0] home;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage

// ===== src/linear_probe_hash_map_top.sv =====
// Linear probe hash map: 64-bit keys to nonzero 32-bit values, fixed table.
// Each command is hashed, queued, then probed slot by slot; a removal also reads
// and rehashes each entry behind the hole until it meets an empty slot.
// Throughput: one command per hash pass while the back end keeps up.
// Reset: the value store is swept to empty, one slot a cycle, with busy high;
// results are strobed one cycle and cannot be stalled.
module linear_probe_hash_map_top
    import lphm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic       front_busy;
    logic       q_full;
    logic       push;
    item_t      push_item;
    logic       pop;
    queue_out_t head;
    logic       clearing;

    assign busy = front_busy || clearing;

    lphm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !clearing),
        .cmd        (cmd),
        .busy       (front_busy),
        .queue_full (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    lphm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    lphm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_MISSING
                  || result.status == ST_FULL))
        else $error("undefined status code");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop && !done)
        else $error("work during clearing pass");

endmodule

// ===== src/lphm_ram.sv =====
// Generic simple dual-port RAM with registered read for the hash map.
// No dependencies.
module lphm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lphm_hash.sv =====
// Multi-cycle home slot hash: 64-bit finalizer built on one shared 32x32
// multiplier. Depends on lphm_pkg.
module lphm_hash
    import lphm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [KEY_W-1:0]     key,
    output logic                 busy,
    output logic                 done,
    output logic [SLOT_BITS-1:0] slot
);

    typedef enum logic [7:0] {
        H_IDLE = 8'b00000001,
        H_M1A  = 8'b00000010,
        H_M1B  = 8'b00000100,
        H_M1C  = 8'b00001000,
        H_MIX  = 8'b00010000,
        H_M2A  = 8'b00100000,
        H_M2B  = 8'b01000000,
        H_M2C  = 8'b10000000
    } hstate_t;

    hstate_t     state_reg, state_next;
    logic        done_reg, done_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] cmul;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [63:0] fin;

    assign prod = 64'(ma) * 64'(mb);
    assign fin  = acc_reg ^ (acc_reg >> SHIFT_C);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        acc_next   = acc_reg;
        cmul       = (state_reg == H_M2A || state_reg == H_M2B || state_reg == H_M2C)
                     ? MIX_C2 : MIX_C1;
        ma         = x_reg[31:0];
        mb         = cmul[31:0];
        case (state_reg)
            H_IDLE:
            begin
                if (go)
                begin
                    x_next     = key ^ (key >> SHIFT_A);
                    state_next = H_M1A;
                end
            end
            H_M1A, H_M2A:
            begin
                acc_next   = prod;
                state_next = (state_reg == H_M1A) ? H_M1B : H_M2B;
            end
            H_M1B, H_M2B:
            begin
                mb         = cmul[63:32];
                acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                state_next = (state_reg == H_M1B) ? H_M1C : H_M2C;
            end
            H_M1C:
            begin
                ma         = x_reg[63:32];
                acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                state_next = H_MIX;
            end
            H_MIX:
            begin
                x_next     = acc_reg ^ (acc_reg >> SHIFT_B);
                state_next = H_M2A;
            end
            H_M2C:
            begin
                ma         = x_reg[63:32];
                acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign busy = (state_reg != H_IDLE) || done_reg;
    assign done = done_reg;
    assign slot = fin[SLOT_BITS-1:0];

endmodule

// ===== src/lphm_front.sv =====
// Front end: accept command beats, hash the key to its home slot, and hand
// the command with its home slot to the queue. Depends on lphm_pkg and lphm_hash.
module lphm_front
    import lphm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  cmd_t  cmd,
    output logic  busy,
    input  logic  queue_full,
    output logic  push,
    output item_t push_item
);

    logic                 pend_reg, pend_next;
    cmd_t                 cmd_reg;
    logic [SLOT_BITS-1:0] home_reg;
    logic                 accept;
    logic                 h_busy, h_done;
    logic [SLOT_BITS-1:0] h_slot;

    assign busy   = h_busy || pend_reg;
    assign accept = start && !busy;
    assign push   = pend_reg && !queue_full;

    lphm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (accept),
        .key   (cmd.lookup_key),
        .busy  (h_busy),
        .done  (h_done),
        .slot  (h_slot)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (h_done)
        begin
            pend_next = 1'b1;
        end
        else if (push)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (h_done)
        begin
            home_reg <= h_slot;
        end
    end

    assign push_item = '{cmd: cmd_reg, home: home_reg};

endmodule

// ===== src/lphm_fifo.sv =====
// Short queue of hashed items between front and back end.
// Depends on lphm_pkg.
module lphm_fifo
    import lphm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  item_t      push_item,
    input  logic       pop,
    output logic       full,
    output queue_out_t head
);

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t         entry_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full       = (cnt_reg == (PW + 1)'(FIFO_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = entry_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW + 1)'(push) - (PW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= push_item;
        end
    end

endmodule

// ===== src/lphm_back.sv =====
// Back end: clear the value store after reset, probe the table, bind,
// overwrite, and remove with backward shift. Depends on lphm_pkg,
// lphm_ram and lphm_hash.
module lphm_back
    import lphm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  queue_out_t head,
    output logic       pop,
    output logic       clearing,
    output logic       done,
    output result_t    result
);

    typedef enum logic [5:0] {
        B_CLEAR  = 6'b000001,
        B_IDLE   = 6'b000010,
        B_PROBE  = 6'b000100,
        B_DEL_RD = 6'b001000,
        B_DEL_HS = 6'b010000,
        B_SPARE  = 6'b100000
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic [SLOT_BITS:0]   cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    result_t              res_reg, res_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [SLOT_BITS-1:0] pos_reg, pos_next;
    logic [SLOT_BITS-1:0] nxt_reg, nxt_next;
    logic [KEY_W-1:0]     nkey_reg, nkey_next;
    logic [VAL_W-1:0]     nval_reg, nval_next;

    logic                 k_we, v_we;
    logic [SLOT_BITS-1:0] k_waddr, v_waddr, raddr;
    logic [KEY_W-1:0]     k_wdata, k_rdata;
    logic [VAL_W-1:0]     v_wdata, v_rdata;
    logic                 h_go, h_busy, h_done;
    logic [SLOT_BITS-1:0] h_slot;
    logic                 hit;
    logic [SLOT_BITS-1:0] d_home, d_hole;

    lphm_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (raddr),
        .rdata (k_rdata)
    );

    lphm_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SLOTS)) u_val_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (raddr),
        .rdata (v_rdata)
    );

    lphm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (h_go),
        .key   (nkey_next),
        .busy  (h_busy),
        .done  (h_done),
        .slot  (h_slot)
    );

    assign hit    = (v_rdata != '0) && (k_rdata == cmd_reg.lookup_key);
    assign d_home = nxt_reg - h_slot;
    assign d_hole = nxt_reg - pos_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        nxt_next   = nxt_reg;
        nkey_next  = nkey_reg;
        nval_next  = nval_reg;
        k_we       = 1'b0;
        v_we       = 1'b0;
        k_waddr    = pos_reg;
        v_waddr    = pos_reg;
        k_wdata    = cmd_reg.lookup_key;
        v_wdata    = cmd_reg.bound_value;
        raddr      = pos_reg;
        h_go       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                v_we     = 1'b1;
                v_waddr  = clr_reg;
                v_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_BITS'(TABLE_SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = head.item.cmd;
                    pos_next   = head.item.home;
                    raddr      = head.item.home;
                    state_next = B_PROBE;
                end
            end
            B_PROBE:
            begin
                if (!hit && v_rdata != '0)
                begin
                    pos_next = pos_reg + 1'b1;
                    raddr    = pos_next;
                end
                else
                begin
                    res_next   = '{found_value: '0, status: ST_OK};
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                    if (cmd_reg.opcode == OP_LOOKUP)
                    begin
                        if (hit)
                        begin
                            res_next.found_value = v_rdata;
                        end
                        else
                        begin
                            res_next.status = ST_MISSING;
                        end
                    end
                    else if (cmd_reg.bound_value == '0)
                    begin
                        if (hit)
                        begin
                            done_next  = 1'b0;
                            nxt_next   = pos_reg + 1'b1;
                            raddr      = nxt_next;
                            state_next = B_DEL_RD;
                        end
                        else
                        begin
                            res_next.status = ST_MISSING;
                        end
                    end
                    else if (hit)
                    begin
                        v_we = 1'b1;
                    end
                    else if (cnt_reg + 1'b1 >= HALF_LOAD)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        k_we     = 1'b1;
                        v_we     = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            B_DEL_RD:
            begin
                if (v_rdata == '0)
                begin
                    v_we       = 1'b1;
                    v_wdata    = '0;
                    cnt_next   = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
                    res_next   = '{found_value: '0, status: ST_OK};
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    nkey_next  = k_rdata;
                    nval_next  = v_rdata;
                    h_go       = 1'b1;
                    state_next = B_DEL_HS;
                end
            end
            B_DEL_HS:
            begin
                if (h_done)
                begin
                    if (d_home >= d_hole)
                    begin
                        k_we     = 1'b1;
                        v_we     = 1'b1;
                        k_wdata  = nkey_reg;
                        v_wdata  = nval_reg;
                        pos_next = nxt_reg;
                    end
                    nxt_next   = nxt_reg + 1'b1;
                    raddr      = nxt_next;
                    state_next = B_DEL_RD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        nxt_reg  <= nxt_next;
        nkey_reg <= nkey_next;
        nval_reg <= nval_next;
    end

    assign clearing = (state_reg == B_CLEAR) || h_busy && 1'b0;
    assign done     = done_reg;
    assign result   = res_reg;

endmodule
